// ===== src/sitra_pkg.sv =====
`default_nettype none
package sitra_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned RADIX_W         = 6;
  localparam int unsigned CHAR_W          = 7;
  localparam int unsigned DIGIT_MAX       = 32;
  localparam int unsigned DIV_STEPS       = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 7'h2D;
  localparam logic [CHAR_W-1:0] NUL_CHAR   = 7'h00;
  localparam logic [CHAR_W-1:0] ZERO_CHAR  = 7'h30;
  localparam logic [CHAR_W-1:0] ALPHA_CHAR = 7'h61;
  localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

  typedef struct packed {
    logic                neg;
    logic                bad;
    logic [RADIX_W-1:0]  radix;
    logic [DATA_W-1:0]   mag;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_EMIT
  } back_state_t;

  // Map a digit value (0 to 35) onto 0-9 then lowercase a-z
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DEC_DIGITS) begin
      ch = ZERO_CHAR + CHAR_W'(d);
    end else begin
      ch = ALPHA_CHAR + CHAR_W'(d - DEC_DIGITS);
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== src/sitra_front.sv =====
`default_nettype none
module sitra_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  input  wire logic signed [31:0]             in_number,
  output logic                                in_full,
  input  wire logic [sitra_pkg::RADIX_W-1:0]  radix,
  output logic                                job_push,
  output sitra_pkg::job_t                     job,
  input  wire logic                           job_full
);

  logic            fv_r, fv_nxt;
  sitra_pkg::job_t job_r, job_nxt;
  logic            accept;

  assign in_full  = fv_r && job_full;
  assign accept   = in_push && !in_full;
  assign job_push = fv_r;
  assign job      = job_r;

  // Classify: sign, magnitude in unsigned arithmetic, radix range check
  always_comb begin
    job_nxt.neg   = in_number[31];
    job_nxt.mag   = in_number[31] ? (32'd0 - 32'(in_number)) : 32'(in_number);
    job_nxt.radix = radix;
    job_nxt.bad   = (radix < sitra_pkg::RADIX_MIN) || (radix > sitra_pkg::RADIX_MAX);
    fv_nxt        = accept || (fv_r && job_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    fv_r && job_full |=> fv_r && $stable(job_r))
    else $error("front job lost while queue full");
  a_bad_range: assert property (@(posedge clk) disable iff (!rst_n)
    fv_r && !job_r.bad |-> job_r.radix >= sitra_pkg::RADIX_MIN &&
                           job_r.radix <= sitra_pkg::RADIX_MAX)
    else $error("out-of-range radix not flagged");
  a_mag_sign: assert property (@(posedge clk) disable iff (!rst_n)
    fv_r && !job_r.neg |-> !job_r.mag[31])
    else $error("positive value with top magnitude bit");
`endif

endmodule
`default_nettype wire

// ===== src/sitra_queue.sv =====
`default_nettype none
module sitra_queue #(
  parameter int unsigned DEPTH = sitra_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire sitra_pkg::job_t din,
  output logic                 full,
  input  wire logic            pop,
  output sitra_pkg::job_t      dout,
  output logic                 empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sitra_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == CW'(DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not advance on transfer in");
`endif

endmodule
`default_nettype wire

// ===== src/sitra_back.sv =====
`default_nettype none
module sitra_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          job_empty,
  input  wire sitra_pkg::job_t               job,
  output logic                               job_pop,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [sitra_pkg::CHAR_W-1:0]       out_ascii_char,
  output logic                               out_last_char,
  output logic                               out_bad_radix
);

  localparam int unsigned DW   = sitra_pkg::DATA_W;
  localparam int unsigned RW   = sitra_pkg::RADIX_W;
  localparam int unsigned SW   = $clog2(sitra_pkg::DIGIT_MAX);
  localparam int unsigned NW   = $clog2(sitra_pkg::DIGIT_MAX + 1);
  localparam int unsigned DCYC = sitra_pkg::DATA_W / sitra_pkg::DIV_STEPS;
  localparam int unsigned TW   = (DCYC > 1) ? $clog2(DCYC) : 1;

  sitra_pkg::back_state_t state_r, state_nxt;

  logic [DW-1:0] quo_r, quo_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] rad_r, rad_nxt;
  logic [TW-1:0] step_r, step_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          sign_r, sign_nxt;
  logic          bad_r, bad_nxt;

  logic [RW-1:0] stk_r [sitra_pkg::DIGIT_MAX];
  logic          stk_we;

  logic                         out_valid_r, out_valid_nxt;
  logic [sitra_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_bad_r, out_bad_nxt;
  logic                         emit_fire, ld;

  logic [DW-1:0] dq;
  logic [RW-1:0] dr;
  logic [RW:0]   dt;
  logic [NW-1:0] cnt_dec;

  // Shared divider: DIV_STEPS restoring steps per cycle on a narrow remainder
  always_comb begin
    dr = rem_r;
    dq = quo_r;
    dt = '0;
    for (int i = 0; i < sitra_pkg::DIV_STEPS; i++) begin
      dt = {dr, dq[DW-1]};
      dq = {dq[DW-2:0], 1'b0};
      if (dt >= {1'b0, rad_r}) begin
        dr    = RW'(dt - {1'b0, rad_r});
        dq[0] = 1'b1;
      end else begin
        dr = dt[RW-1:0];
      end
    end
  end

  assign cnt_dec   = cnt_r - 1'b1;
  assign ld        = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_last_char  = out_last_r;
  assign out_bad_radix  = out_bad_r;

  always_comb begin
    state_nxt    = state_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    rad_nxt      = rad_r;
    step_nxt     = step_r;
    cnt_nxt      = cnt_r;
    sign_nxt     = sign_r;
    bad_nxt      = bad_r;
    job_pop      = 1'b0;
    stk_we       = 1'b0;
    emit_fire    = 1'b0;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    out_bad_nxt  = out_bad_r;
    unique case (state_r)
      sitra_pkg::B_IDLE: begin
        if (!job_empty) begin
          job_pop  = 1'b1;
          quo_nxt  = job.mag;
          rem_nxt  = '0;
          rad_nxt  = job.radix;
          step_nxt = '0;
          cnt_nxt  = '0;
          sign_nxt = job.neg && !job.bad;
          bad_nxt  = job.bad;
          state_nxt = job.bad ? sitra_pkg::B_EMIT : sitra_pkg::B_DIV;
        end
      end
      sitra_pkg::B_DIV: begin
        quo_nxt  = dq;
        rem_nxt  = dr;
        step_nxt = step_r + 1'b1;
        if (step_r == TW'(DCYC - 1)) begin
          stk_we   = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          rem_nxt  = '0;
          step_nxt = '0;
          if (dq == '0 || cnt_r == NW'(sitra_pkg::DIGIT_MAX - 1)) begin
            state_nxt = sitra_pkg::B_EMIT;
          end
        end
      end
      sitra_pkg::B_EMIT: begin
        if (ld) begin
          emit_fire = 1'b1;
          if (bad_r) begin
            out_char_nxt = sitra_pkg::NUL_CHAR;
            out_last_nxt = 1'b1;
            out_bad_nxt  = 1'b1;
            state_nxt    = sitra_pkg::B_IDLE;
          end else if (sign_r) begin
            out_char_nxt = sitra_pkg::MINUS_CHAR;
            out_last_nxt = 1'b0;
            out_bad_nxt  = 1'b0;
            sign_nxt     = 1'b0;
          end else begin
            out_char_nxt = sitra_pkg::digit_char(stk_r[cnt_dec[SW-1:0]]);
            out_last_nxt = (cnt_r == NW'(1));
            out_bad_nxt  = 1'b0;
            cnt_nxt      = cnt_dec;
            if (cnt_r == NW'(1)) begin
              state_nxt = sitra_pkg::B_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = sitra_pkg::B_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && !out_pop) || emit_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sitra_pkg::B_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      sign_r      <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      sign_r      <= sign_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    rad_r      <= rad_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
    if (stk_we) begin
      stk_r[cnt_r[SW-1:0]] <= dr;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(sitra_pkg::DIGIT_MAX))
    else $error("digit stack overrun");
  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sitra_pkg::B_DIV |-> rem_r < rad_r)
    else $error("partial remainder not below radix");
  a_digits_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sitra_pkg::B_EMIT && !bad_r && !sign_r |-> cnt_r != '0)
    else $error("emission with empty digit stack");
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_last_r && out_char_r == sitra_pkg::NUL_CHAR)
    else $error("error result not a lone NUL");
`endif

endmodule
`default_nettype wire

// ===== src/signed_int_to_radix_ascii.sv =====
// The shared divider forms 8 quotient bits a cycle; a number enters it only after every
// character of the number before has been loaded into the output register.
// Characters leave at one per cycle once a number's digits are all formed, as long as the
// receiver keeps popping.
// Reset (synchronous, rst_n low): radix returns to 10, all queues and results empty.
`default_nettype none
module signed_int_to_radix_ascii #(
  parameter int unsigned QUEUE_DEPTH = sitra_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  input  wire logic signed [31:0]            in_number,
  output logic                               in_full,
  input  wire logic                          cfg_we,
  input  wire logic [sitra_pkg::RADIX_W-1:0] cfg_radix,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [sitra_pkg::CHAR_W-1:0]       out_ascii_char,
  output logic                               out_last_char,
  output logic                               out_bad_radix
);

  // Radix register; the user must write it only while the block is idle, the block itself does not enforce it
  logic [sitra_pkg::RADIX_W-1:0] radix_r, radix_nxt;

  sitra_pkg::job_t f_job, q_job;
  logic            f_push, q_full, q_empty, q_pop;

  assign radix_nxt = cfg_we ? cfg_radix : radix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= sitra_pkg::RADIX_RESET;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  // Front: take the transfer, split sign from magnitude, flag a bad radix
  sitra_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_number (in_number),
    .in_full   (in_full),
    .radix     (radix_r),
    .job_push  (f_push),
    .job       (f_job),
    .job_full  (q_full)
  );

  // Short job queue: decouple classification from the slow digit loop
  sitra_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_job),
    .empty (q_empty)
  );

  // Back: divide out digits least significant first onto a stack, then drain sign and
  // digits most significant first, or a lone NUL for a bad radix, through the output register
  sitra_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_empty      (q_empty),
    .job            (q_job),
    .job_pop        (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_ascii_char (out_ascii_char),
    .out_last_char  (out_last_char),
    .out_bad_radix  (out_bad_radix)
  );

`ifndef SYNTHESIS
  a_radix_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> $stable(radix_r))
    else $error("radix changed without a write");
  a_radix_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> radix_r == $past(cfg_radix))
    else $error("radix write not taken");
  a_reset_radix: assert property (@(posedge clk)
    !rst_n |=> radix_r == sitra_pkg::RADIX_RESET)
    else $error("radix not restored by reset");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/radix_text_checker.sv =====
`timescale 1ns / 100ps
module radix_text_checker
  import sitra_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  logic signed [31:0]  in_number,
  input  logic                cfg_we,
  input  logic [RADIX_W-1:0]  cfg_radix,
  input  logic                out_empty,
  input  logic                out_pop,
  input  logic [CHAR_W-1:0]   out_ascii_char,
  input  logic                out_last_char,
  input  logic                out_bad_radix,
  output int                  mismatches,
  output int                  pending,
  output int                  chars_checked,
  output int                  bad_checked
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              bad;
  } glyph_t;

  localparam string GLYPHS = "0123456789abcdefghijklmnopqrstuvwxyz";

  glyph_t             text_q[$];
  logic [RADIX_W-1:0] base_now;
  int                 miss_cnt = 0;
  int                 char_cnt = 0;
  int                 bad_cnt  = 0;

  initial begin
    mismatches    = 0;
    pending       = 0;
    chars_checked = 0;
    bad_checked   = 0;
    base_now      = RADIX_RESET;
  end

  // Queue up the characters that one number should turn into
  task automatic spell_number(input logic [31:0] num, input logic [RADIX_W-1:0] base);
    logic [31:0]        mag;
    logic [RADIX_W-1:0] digs[DIGIT_MAX];
    int                 n;
    glyph_t             g;
    if (base < RADIX_MIN || base > RADIX_MAX) begin
      g = '{ch: NUL_CHAR, last: 1'b1, bad: 1'b1};
      text_q.push_back(g);
      return;
    end
    mag = num[31] ? (32'd0 - num) : num;
    n = 0;
    do begin
      digs[n] = RADIX_W'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0 && n < DIGIT_MAX);
    if (num[31]) begin
      g = '{ch: MINUS_CHAR, last: 1'b0, bad: 1'b0};
      text_q.push_back(g);
    end
    for (int i = n - 1; i >= 0; i--) begin
      g = '{ch: CHAR_W'(GLYPHS[digs[i]]), last: (i == 0), bad: 1'b0};
      text_q.push_back(g);
    end
  endtask

  always @(posedge clk) begin
    glyph_t want;
    if (!rst_n) begin
      base_now = RADIX_RESET;
      text_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        char_cnt++;
        if (out_bad_radix) bad_cnt++;
        if (text_q.size() == 0) begin
          miss_cnt++;
          if (miss_cnt <= 10)
            $display("unexpected char %02h last %0b bad %0b at %0t",
                     out_ascii_char, out_last_char, out_bad_radix, $time);
        end else begin
          want = text_q.pop_front();
          if (want.ch !== out_ascii_char || want.last !== out_last_char ||
              want.bad !== out_bad_radix) begin
            miss_cnt++;
            if (miss_cnt <= 10)
              $display("char mismatch at %0t: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                       $time, want.ch, want.last, want.bad,
                       out_ascii_char, out_last_char, out_bad_radix);
          end
        end
      end
      if (in_push && !in_full) spell_number(in_number, base_now);
      if (cfg_we) base_now = cfg_radix;
    end
    mismatches    <= miss_cnt;
    pending       <= text_q.size();
    chars_checked <= char_cnt;
    bad_checked   <= bad_cnt;
  end

endmodule

// ===== tb/sv/signed_int_to_radix_ascii_test.sv =====
`timescale 1ns / 100ps
module signed_int_to_radix_ascii_test;
  import sitra_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 200;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_push        = 1'b0;
  logic signed [31:0]  in_number      = '0;
  logic                in_full;
  logic                cfg_we         = 1'b0;
  logic [RADIX_W-1:0]  cfg_radix      = RADIX_RESET;
  logic                out_empty;
  logic                out_pop        = 1'b0;
  logic [CHAR_W-1:0]   out_ascii_char;
  logic                out_last_char;
  logic                out_bad_radix;

  int mismatches;
  int pending;
  int chars_checked;
  int bad_checked;

  // Idling odds in percent per cycle, changed between phases
  int send_idle_pct = 21;
  int recv_idle_pct = 66;
  // Long receiver hold: the sender asks, the receiver counts it out itself
  int hold_ask      = 0;
  int numbers_sent  = 0;
  int radix_writes  = 0;
  int quiet_cycles  = 0;

  signed_int_to_radix_ascii uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_number      (in_number),
    .in_full        (in_full),
    .cfg_we         (cfg_we),
    .cfg_radix      (cfg_radix),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_ascii_char (out_ascii_char),
    .out_last_char  (out_last_char),
    .out_bad_radix  (out_bad_radix)
  );

  radix_text_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_number      (in_number),
    .cfg_we         (cfg_we),
    .cfg_radix      (cfg_radix),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_ascii_char (out_ascii_char),
    .out_last_char  (out_last_char),
    .out_bad_radix  (out_bad_radix),
    .mismatches     (mismatches),
    .pending        (pending),
    .chars_checked  (chars_checked),
    .bad_checked    (bad_checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog: give up after a long run of cycles without any transfer
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d characters outstanding",
               WATCHDOG_LIMIT, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: pop at random, or hold off for a long stretch when asked
  initial begin
    int hold_done;
    hold_done = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_ask != hold_done) begin
        hold_done = hold_ask;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one number, with random gaps first; leave push high after the transfer
  task automatic send_number(input logic [31:0] num);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push   <= 1'b1;
    in_number <= num;
    do @(posedge clk); while (in_full);
    numbers_sent++;
  endtask

  // Drop push and wait until every queued character has been popped
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write the radix only once the block has gone quiet
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_radix <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    radix_writes++;
  endtask

  // Mix of full-range values, small values, extremes and powers of the base
  function automatic logic [31:0] pick_number(input logic [RADIX_W-1:0] base);
    logic [63:0] p;
    logic [31:0] v;
    logic        signable;
    int          k;
    v = $urandom;
    signable = 1'b1;
    case ($urandom_range(5))
      0: begin
        signable = 1'b0;
      end
      1: begin
        v = $urandom_range(999);
      end
      2: begin
        signable = 1'b0;
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      3: begin
        if (base >= RADIX_MIN && base <= RADIX_MAX) begin
          p = 64'd1;
          k = $urandom_range(1, 31);
          repeat (k) if (p * base <= 64'h8000_0000) p = p * base;
          v = p[31:0] + $urandom_range(2) - 1;
        end
      end
      default: begin
        v = v >> $urandom_range(31);
      end
    endcase
    if (signable && $urandom_range(1)) v = 32'd0 - v;
    return v;
  endfunction

  task automatic random_set(input logic [RADIX_W-1:0] r, input int count);
    set_radix(r);
    repeat (count) send_number(pick_number(r));
  endtask

  initial begin
    logic [RADIX_W-1:0] r;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender idles lightly, receiver heavily
    send_idle_pct = 21;
    recv_idle_pct = 66;

    // Directed: reset radix of ten first, then the extremes of base and value
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'hffff_ffff);
    send_number(32'h7fff_ffff);
    send_number(32'h8000_0000);
    send_number(32'd9);
    send_number(32'hffff_fff6);
    send_number(32'd1_000_000_000);
    // Binary: the longest strings, most negative value included
    set_radix(6'd2);
    send_number(32'h8000_0000);
    send_number(32'hffff_ffff);
    send_number(32'd0);
    send_number(32'h7fff_ffff);
    // Base 36 reaches the last letter
    set_radix(6'd36);
    send_number(32'd35);
    send_number(32'd36);
    send_number(32'hffff_faf1);
    send_number(32'h8000_0000);
    send_number(32'h7fff_ffff);
    set_radix(6'd16);
    send_number(32'hdead_beef);
    send_number(32'd255);
    // Out-of-range bases on either side give the single error result
    set_radix(6'd0);
    send_number(32'd5);
    set_radix(6'd1);
    send_number(32'hffff_fffb);
    set_radix(6'd37);
    send_number(32'd0);
    set_radix(6'd63);
    send_number(32'h8000_0000);

    random_set(6'd36, 24);
    random_set(6'd0, 8);
    r = $urandom_range(RADIX_MIN, RADIX_MAX);
    random_set(r, 24);
    random_set(6'd16, 24);

    // Phase two: the other way round
    wait_drained();
    send_idle_pct = 66;
    recv_idle_pct = 21;
    random_set(6'd63, 8);
    random_set(6'd3, 24);
    random_set(6'd1, 8);
    r = $urandom_range(0, 63);
    random_set(r, 24);

    // Phase three: no idling; hold the receiver off while the sender keeps offering
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_set(6'd37, 8);
    set_radix(6'd2);
    hold_ask <= hold_ask + 1;
    repeat (24) send_number(pick_number(6'd2));
    random_set(6'd10, 24);
    r = $urandom_range(RADIX_MIN, RADIX_MAX);
    random_set(r, 24);

    // Drain, then give any stray character time to show up
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d numbers into %0d characters (%0d bad-radix results), %0d radix writes",
             numbers_sent, chars_checked, bad_checked, radix_writes);
    $display("Covered sender-heavy and receiver-heavy idling, none at all, and a long output stall");
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
